@@ hw/rtl/circular_deque_defines.svh @@
// ----------------------------------------------------------------------------
// circular_deque_defines: assertion macros
// Shared concurrent assertion forms for the deque RTL.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_DEQUE_DEFINES_SVH
`define CIRCULAR_DEQUE_DEFINES_SVH

// check a property on every rising clock edge outside reset
`define CDQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that a condition never holds outside reset
`define CDQ_NEVER(lbl, cond, msg) \
  `CDQ_ASSERT(lbl, !(cond), msg)

`endif

@@ hw/rtl/cdq_pkg.sv @@
// ----------------------------------------------------------------------------
// cdq_pkg
// Types, codes and index helpers for the circular deque.
// ----------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

  localparam int unsigned DEPTH = 8;
  localparam int unsigned IdxW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(DEPTH - 1);

  localparam logic [2:0] ActPushFront = 3'd0;
  localparam logic [2:0] ActPushRear  = 3'd1;
  localparam logic [2:0] ActPopFront  = 3'd2;
  localparam logic [2:0] ActPopRear   = 3'd3;
  localparam logic [2:0] ActQuery     = 3'd4;

  localparam logic [1:0] StDone  = 2'd0;
  localparam logic [1:0] StFull  = 2'd1;
  localparam logic [1:0] StEmpty = 2'd2;

  typedef enum logic {
    CdqIdle,
    CdqRead
  } cdq_state_e;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] value;
  } cdq_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] popped_value;
    logic signed [31:0] front_value;
    logic signed [31:0] rear_value;
    logic               is_full;
    logic               is_empty;
  } cdq_out_t;

  function automatic logic [IdxW-1:0] idx_inc(input logic [IdxW-1:0] i);
    return (i == LastIdx) ? '0 : i + IdxW'(1);
  endfunction

  function automatic logic [IdxW-1:0] idx_dec(input logic [IdxW-1:0] i);
    return (i == '0) ? LastIdx : i - IdxW'(1);
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/cdq_ram.sv @@
// ----------------------------------------------------------------------------
// cdq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 8,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/circular_deque.sv @@
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue over a circular slot RAM with cached end values.
//
//   channel   direction  handshake             payload
//   command   in         start & !busy         in_i     (cdq_in_t)
//   result    out        done_o, one cycle     result_o (cdq_out_t)
//
// Pushes, queries, spare action codes, rejected actions and a pop of the last
// element return their result in the cycle after the transaction.
// Any other pop goes through the read state; busy is high for one cycle while
// the slot RAM reads the new end element through its registered read port.
// Reset clears pointers and the empty flag; slots need no clearing pass.
// The receiver cannot stall; every result strobes for one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "circular_deque_defines.svh"

module circular_deque (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire cdq_pkg::cdq_in_t in_i,
  output logic                  done_o,
  output cdq_pkg::cdq_out_t     result_o
);

  import cdq_pkg::*;

  cdq_state_e state_q, state_d;

  logic [IdxW-1:0]    front_q, front_d;
  logic [IdxW-1:0]    rear_q, rear_d;
  logic               empty_q, empty_d;
  logic signed [31:0] fval_q, fval_d;
  logic signed [31:0] rval_q, rval_d;
  logic signed [31:0] pend_q, pend_d;
  logic               pend_front_q, pend_front_d;
  logic               done_q, done_d;
  cdq_out_t           result_q, result_d;

  logic               go_read;
  logic               full_now;
  logic               we;
  logic [IdxW-1:0]    waddr;
  logic               re;
  logic [IdxW-1:0]    raddr;
  logic [31:0]        rdata;
  logic [1:0]         status_d;
  logic signed [31:0] popped_d;

  cdq_ram #(
    .Width(32),
    .Depth(DEPTH),
    .AddrW(IdxW)
  ) u_slots (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(in_i.value),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign full_now = !empty_q && (front_q == idx_inc(rear_q));

  always_comb begin
    front_d      = front_q;
    rear_d       = rear_q;
    empty_d      = empty_q;
    fval_d       = fval_q;
    rval_d       = rval_q;
    pend_d       = pend_q;
    pend_front_d = pend_front_q;
    status_d     = StDone;
    popped_d     = '0;
    we           = 1'b0;
    waddr        = front_q;
    re           = 1'b0;
    raddr        = front_q;
    go_read      = 1'b0;
    if (state_q == CdqIdle && start) begin
      case (in_i.action)
        ActPushFront, ActPushRear: begin
          if (full_now) begin
            status_d = StFull;
          end else if (empty_q) begin
            front_d = '0;
            rear_d  = '0;
            empty_d = 1'b0;
            fval_d  = in_i.value;
            rval_d  = in_i.value;
            we      = 1'b1;
            waddr   = '0;
          end else if (in_i.action == ActPushFront) begin
            front_d = idx_dec(front_q);
            fval_d  = in_i.value;
            we      = 1'b1;
            waddr   = front_d;
          end else begin
            rear_d = idx_inc(rear_q);
            rval_d = in_i.value;
            we     = 1'b1;
            waddr  = rear_d;
          end
        end
        ActPopFront, ActPopRear: begin
          if (empty_q) begin
            status_d = StEmpty;
          end else begin
            popped_d = (in_i.action == ActPopFront) ? fval_q : rval_q;
            pend_d   = popped_d;
            if (front_q == rear_q) begin
              front_d = '0;
              rear_d  = '0;
              empty_d = 1'b1;
            end else if (in_i.action == ActPopFront) begin
              front_d      = idx_inc(front_q);
              raddr        = front_d;
              re           = 1'b1;
              go_read      = 1'b1;
              pend_front_d = 1'b1;
            end else begin
              rear_d       = idx_dec(rear_q);
              raddr        = rear_d;
              re           = 1'b1;
              go_read      = 1'b1;
              pend_front_d = 1'b0;
            end
          end
        end
        ActQuery: begin
        end
        default: begin
        end
      endcase
    end else if (state_q == CdqRead) begin
      popped_d = pend_q;
      if (pend_front_q) begin
        fval_d = $signed(rdata);
      end else begin
        rval_d = $signed(rdata);
      end
    end
  end

  always_comb begin
    result_d.status       = status_d;
    result_d.popped_value = popped_d;
    result_d.front_value  = empty_d ? '0 : fval_d;
    result_d.rear_value   = empty_d ? '0 : rval_d;
    result_d.is_full      = !empty_d && (front_d == idx_inc(rear_d));
    result_d.is_empty     = empty_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      CdqIdle: begin
        if (start && go_read) begin
          state_d = CdqRead;
        end
      end
      CdqRead: begin
        state_d = CdqIdle;
      end
      default: begin
        state_d = CdqIdle;
      end
    endcase
  end

  always_comb begin
    busy   = (state_q == CdqRead);
    done_d = (state_q == CdqIdle && start && !go_read) || (state_q == CdqRead);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CdqIdle;
      front_q <= '0;
      rear_q  <= '0;
      empty_q <= 1'b1;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      rear_q  <= rear_d;
      empty_q <= empty_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fval_q       <= fval_d;
    rval_q       <= rval_d;
    pend_q       <= pend_d;
    pend_front_q <= pend_front_d;
    result_q     <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  `CDQ_ASSERT(a_read_one_cycle, (state_q == CdqRead) |=> (state_q == CdqIdle), "read wait too long")
  `CDQ_ASSERT(a_read_gives_result, (state_q == CdqRead) |=> done_o, "read lost its result")
  `CDQ_ASSERT(a_empty_ptrs, empty_q |-> (front_q == '0 && rear_q == '0), "empty with pointers")
  `CDQ_NEVER(a_full_and_empty, done_o && result_o.is_full && result_o.is_empty, "full and empty")

endmodule

`default_nettype wire

@@ sim/tb_circular_deque.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circular_deque
// Self-checking bench for the circular deque. A short table of commands covers
// empty and full rejection, pushes into an empty deque, pops of the last
// element, pointer wrap at both ends, extreme values and the spare action
// codes. Random commands follow in bursts that lean toward filling or draining
// so that both ends are hit often. Each result is checked against an in-bench
// deque model or a table row's result. Random idle gaps fall between commands.
// ----------------------------------------------------------------------------

module tb_circular_deque;

  import cdq_pkg::*;

  localparam int unsigned      RandCmds  = 1400;
  localparam int unsigned      CycleCap  = 250000;
  localparam int unsigned      DrainWait = 8;
  localparam int unsigned      MaxShown  = 10;
  localparam logic [2:0]       ActMax    = 3'b111;
  localparam logic signed [31:0] ValMin  = 32'sh8000_0000;
  localparam logic signed [31:0] ValMax  = 32'sh7fff_ffff;

  typedef struct {
    cdq_in_t  cmd;
    bit       typed;
    cdq_out_t want;
  } cmd_row_t;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  cdq_in_t  in_i;
  logic     done_o;
  cdq_out_t result_o;

  logic     use_typed;
  cdq_out_t typed_want;

  cdq_out_t    expected_q[$];
  cmd_row_t    cmd_table[$];
  int unsigned accept_cnt;
  int unsigned result_cnt;
  int unsigned err_cnt;
  int unsigned cycle_cnt;
  int unsigned full_rej_cnt;
  int unsigned empty_rej_cnt;
  int unsigned full_seen_cnt;
  int unsigned empty_seen_cnt;

  // deque model state
  logic [31:0] slot_mem[DEPTH];
  int unsigned head_pos;
  int unsigned tail_pos;
  int unsigned fill_cnt;

  circular_deque dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .in_i    (in_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  function automatic cdq_out_t deque_apply(input cdq_in_t cmd);
    cdq_out_t res;
    res = '0;
    res.status = StDone;
    if (cmd.action == ActPushFront || cmd.action == ActPushRear) begin
      if (fill_cnt == DEPTH) begin
        res.status = StFull;
      end else if (fill_cnt == 0) begin
        head_pos = 0;
        tail_pos = 0;
        slot_mem[0] = cmd.value;
        fill_cnt = 1;
      end else if (cmd.action == ActPushFront) begin
        head_pos = (head_pos + DEPTH - 1) % DEPTH;
        slot_mem[head_pos] = cmd.value;
        fill_cnt++;
      end else begin
        tail_pos = (tail_pos + 1) % DEPTH;
        slot_mem[tail_pos] = cmd.value;
        fill_cnt++;
      end
    end else if (cmd.action == ActPopFront || cmd.action == ActPopRear) begin
      if (fill_cnt == 0) begin
        res.status = StEmpty;
      end else begin
        res.popped_value = slot_mem[cmd.action == ActPopFront ? head_pos : tail_pos];
        if (fill_cnt == 1) begin
          head_pos = 0;
          tail_pos = 0;
        end else if (cmd.action == ActPopFront) begin
          head_pos = (head_pos + 1) % DEPTH;
        end else begin
          tail_pos = (tail_pos + DEPTH - 1) % DEPTH;
        end
        fill_cnt--;
      end
    end
    res.front_value = (fill_cnt == 0) ? '0 : slot_mem[head_pos];
    res.rear_value  = (fill_cnt == 0) ? '0 : slot_mem[tail_pos];
    res.is_full     = (fill_cnt == DEPTH);
    res.is_empty    = (fill_cnt == 0);
    return res;
  endfunction

  // accept transactions and check results
  always @(posedge clk_i) begin
    cdq_out_t want;
    cdq_out_t got;
    if (rst_ni) begin
      if (done_o) begin
        got = result_o;
        result_cnt++;
        if (expected_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MaxShown)
            $display("ERROR: unexpected result status=%0d popped=%0d", got.status,
                     got.popped_value);
        end else begin
          want = expected_q.pop_front();
          if (got.status !== want.status || got.popped_value !== want.popped_value ||
              got.front_value !== want.front_value || got.rear_value !== want.rear_value ||
              got.is_full !== want.is_full || got.is_empty !== want.is_empty) begin
            err_cnt++;
            if (err_cnt <= MaxShown) begin
              $display("ERROR: result %0d mismatch", result_cnt);
              $display("  expected st=%0d pop=%0d front=%0d rear=%0d full=%b empty=%b",
                       want.status, want.popped_value, want.front_value,
                       want.rear_value, want.is_full, want.is_empty);
              $display("  actual   st=%0d pop=%0d front=%0d rear=%0d full=%b empty=%b",
                       got.status, got.popped_value, got.front_value,
                       got.rear_value, got.is_full, got.is_empty);
            end
          end
        end
      end
      if (start && !busy) begin
        want = deque_apply(in_i);
        if (use_typed)
          want = typed_want;
        if (want.status == StFull) full_rej_cnt++;
        if (want.status == StEmpty) empty_rej_cnt++;
        if (want.is_full) full_seen_cnt++;
        if (want.is_empty) empty_seen_cnt++;
        expected_q.push_back(want);
        accept_cnt++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleCap) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_cnt,
               expected_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  function automatic cdq_out_t make_out(input logic [1:0] st, input logic [31:0] pop,
                                        input logic [31:0] fr, input logic [31:0] rr,
                                        input logic full, input logic empty);
    cdq_out_t o;
    o.status       = st;
    o.popped_value = pop;
    o.front_value  = fr;
    o.rear_value   = rr;
    o.is_full      = full;
    o.is_empty     = empty;
    return o;
  endfunction

  function automatic void add_row(input logic [2:0] act, input logic [31:0] val,
                                  input bit typed, input cdq_out_t want);
    cmd_row_t r;
    r.cmd.action = act;
    r.cmd.value  = val;
    r.typed      = typed;
    r.want       = want;
    cmd_table.push_back(r);
  endfunction

  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // call at a falling edge; returns at the falling edge after acceptance, or after the idle gap that follows it
  task automatic issue(input cdq_in_t cmd, input bit typed, input cdq_out_t want,
                       input int unsigned gap);
    int unsigned seen;
    seen = accept_cnt;
    start      <= 1'b1;
    in_i       <= cmd;
    use_typed  <= typed;
    typed_want <= want;
    do @(negedge clk_i); while (accept_cnt == seen);
    if (gap != 0) begin
      start <= 1'b0;
      in_i  <= {3'(ActMax), 32'($urandom)};
      repeat (gap) @(negedge clk_i);
    end
  endtask

  initial begin
    cdq_in_t     cmd;
    cdq_out_t    none;
    int unsigned burst_len;
    int unsigned push_bias;
    int unsigned r;
    int unsigned sent;
    bit          quiet;

    none       = '0;
    rst_ni     = 1'b0;
    start      = 1'b0;
    in_i       = '0;
    use_typed  = 1'b0;
    typed_want = '0;
    head_pos   = 0;
    tail_pos   = 0;
    fill_cnt   = 0;
    foreach (slot_mem[i]) slot_mem[i] = '0;

    add_row(ActQuery,     32'd0, 1, make_out(StDone, 0, 0, 0, 1'b0, 1'b1));
    add_row(ActPopFront,  32'd5, 1, make_out(StEmpty, 0, 0, 0, 1'b0, 1'b1));
    add_row(ActPopRear,   32'd9, 1, make_out(StEmpty, 0, 0, 0, 1'b0, 1'b1));
    add_row(ActPushRear,  ValMax, 1, make_out(StDone, 0, ValMax, ValMax, 1'b0, 1'b0));
    add_row(ActPopFront,  32'd0, 1, make_out(StDone, ValMax, 0, 0, 1'b0, 1'b1));
    add_row(ActPushFront, ValMin, 1, make_out(StDone, 0, ValMin, ValMin, 1'b0, 1'b0));
    add_row(ActPushFront, 32'd1, 0, none);
    add_row(ActPushRear,  32'hffff_ffff, 0, none);
    add_row(ActPushFront, 32'd2, 0, none);
    add_row(ActPushRear,  32'd3, 0, none);
    add_row(ActPushFront, 32'd4, 0, none);
    add_row(ActPushRear,  32'd5, 0, none);
    add_row(ActPushFront, 32'd6, 0, none);
    add_row(ActPushRear,  32'd7, 1, make_out(StFull, 0, 32'd6, 32'd5, 1'b1, 1'b0));
    add_row(ActPushFront, 32'd8, 1, make_out(StFull, 0, 32'd6, 32'd5, 1'b1, 1'b0));
    add_row(ActQuery + 3'd1, 32'hdead_beef, 0, none);
    add_row(ActMax,       32'h1234_5678, 0, none);
    add_row(ActPopRear,   32'd0, 0, none);
    add_row(ActPopFront,  32'd0, 0, none);
    add_row(ActQuery + 3'd2, 32'h0, 0, none);
    add_row(ActPopRear,   32'd0, 0, none);
    add_row(ActPopRear,   32'd0, 0, none);
    add_row(ActPopRear,   32'd0, 0, none);
    add_row(ActPopRear,   32'd0, 0, none);

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (cmd_table[i])
      issue(cmd_table[i].cmd, cmd_table[i].typed, cmd_table[i].want, pick_gap(1'b0));

    sent = 0;
    while (sent < RandCmds) begin
      burst_len = $urandom_range(8, 40);
      r = $urandom_range(0, 2);
      push_bias = (r == 0) ? 15 : (r == 1) ? 50 : 85;
      quiet = ($urandom_range(0, 3) == 0);
      repeat (burst_len) begin
        r = $urandom_range(0, 99);
        if (r < 4)
          cmd.action = 3'($urandom_range(ActQuery, ActMax));
        else if ($urandom_range(0, 99) < push_bias)
          cmd.action = 3'($urandom_range(ActPushFront, ActPushRear));
        else
          cmd.action = 3'($urandom_range(ActPopFront, ActPopRear));
        r = $urandom_range(0, 99);
        cmd.value = (r < 4) ? ValMin : (r < 8) ? ValMax : (r < 10) ? 32'd0 : $urandom;
        issue(cmd, 1'b0, none, pick_gap(quiet));
        sent++;
      end
    end

    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("%0d commands checked: %0d rejected pushes, %0d rejected pops",
             result_cnt, full_rej_cnt, empty_rej_cnt);
    $display("deque full after %0d commands, empty after %0d; %0d mismatches",
             full_seen_cnt, empty_seen_cnt, err_cnt);
    if (err_cnt == 0 && expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/cdq_pkg.sv
hw/rtl/cdq_ram.sv
hw/rtl/circular_deque.sv
sim/tb_circular_deque.sv
